// File: hdl/itp_pkg.sv
`timescale 1ns / 1ps

package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   // The top two entries live in registers; the entries below them live in an array.
   localparam int BELOW_DEPTH = STACK_DEPTH - 2;
   localparam int BELOW_AW    = (BELOW_DEPTH > 1) ? $clog2(BELOW_DEPTH) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef logic [1:0] prec_type;

   localparam prec_type PREC_NONE = 2'd0;
   localparam prec_type PREC_ADD  = 2'd1;
   localparam prec_type PREC_MUL  = 2'd2;
   localparam prec_type PREC_POW  = 2'd3;

   typedef enum logic [2:0] {
      KIND_ALNUM,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_OPER,
      KIND_OTHER
   } kind_type;

   typedef enum logic [1:0] {
      ST_FETCH,
      ST_WORK,
      ST_FLUSH
   } back_state_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expr;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       is_terminator;
      logic       last_in_run;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      prec_type   prec;
      logic [7:0] symbol;
      logic       end_of_expr;
   } cmd_type;

   function automatic prec_type prec_of(input logic [7:0] ch);
      prec_type p;
      p = PREC_NONE;
      if (ch == CH_PLUS || ch == CH_MINUS) begin
         p = PREC_ADD;
      end else if (ch == CH_STAR || ch == CH_SLASH) begin
         p = PREC_MUL;
      end else if (ch == CH_CARET) begin
         p = PREC_POW;
      end
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
             (ch >= 8'h61 && ch <= 8'h7A);
   endfunction

endpackage

// File: hdl/itp_front.sv
`timescale 1ns / 1ps

module itp_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  itp_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output itp_pkg::cmd_type  q_cmd
);

   itp_pkg::prec_type prec;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign prec      = itp_pkg::prec_of(req_data.symbol);

   always_comb begin
      q_cmd.symbol      = req_data.symbol;
      q_cmd.end_of_expr = req_data.end_of_expr;
      q_cmd.prec        = prec;
      if (itp_pkg::is_alnum(req_data.symbol)) begin
         q_cmd.kind = itp_pkg::KIND_ALNUM;
      end else if (req_data.symbol == itp_pkg::CH_LPAREN) begin
         q_cmd.kind = itp_pkg::KIND_LPAREN;
      end else if (req_data.symbol == itp_pkg::CH_RPAREN) begin
         q_cmd.kind = itp_pkg::KIND_RPAREN;
      end else if (prec != itp_pkg::PREC_NONE) begin
         q_cmd.kind = itp_pkg::KIND_OPER;
      end else begin
         q_cmd.kind = itp_pkg::KIND_OTHER;
      end
   end

endmodule

// File: hdl/itp_queue.sv
`timescale 1ns / 1ps

module itp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  itp_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output itp_pkg::cmd_type  q_cmd
);

   itp_pkg::cmd_type                  slot_ff [itp_pkg::QUEUE_DEPTH];
   logic [itp_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [itp_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [itp_pkg::QUEUE_CW-1:0]      count_ff, count_in;
   logic                              do_pop;

   assign full    = count_ff == itp_pkg::QUEUE_CW'(itp_pkg::QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_cmd   = slot_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      // Depth is a power of two, so the pointers wrap on their own.
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/itp_back.sv
`timescale 1ns / 1ps

module itp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  itp_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itp_pkg::rsp_type  rsp_data
);

   itp_pkg::back_state_type          state_ff, state_in;
   itp_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [itp_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [7:0]                       top_ff, top_in;
   logic [7:0]                       next_ff, next_in;
   logic [7:0]                       third_ff;
   logic [7:0]                       stack_mem [itp_pkg::BELOW_DEPTH];
   logic                             rsp_valid_ff, rsp_valid_in;
   itp_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                             has_top, is_full, two_up, out_free;
   logic                             do_push, do_pop, emit;
   logic [7:0]                       push_char;
   itp_pkg::rsp_type                 emit_data;
   logic [itp_pkg::COUNT_W-1:0]      count_m1, count_m2, count_m4;
   logic [7:0]                       below_rd;
   itp_pkg::back_state_type          after_state;

   assign has_top  = count_ff != '0;
   assign two_up   = count_ff > itp_pkg::COUNT_W'(1);
   assign is_full  = count_ff == itp_pkg::COUNT_W'(itp_pkg::STACK_DEPTH);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign count_m1 = count_ff - itp_pkg::COUNT_W'(1);
   assign count_m2 = count_ff - itp_pkg::COUNT_W'(2);
   assign count_m4 = count_ff - itp_pkg::COUNT_W'(4);
   // Entry just under the top; only meaningful with two or more entries.
   assign below_rd = next_ff;

   assign after_state = cmd_ff.end_of_expr ? itp_pkg::ST_FLUSH : itp_pkg::ST_FETCH;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      q_pop     = 1'b0;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      push_char = cmd_ff.symbol;
      emit      = 1'b0;
      emit_data.out_char      = top_ff;
      emit_data.is_terminator = 1'b0;
      emit_data.last_in_run   = 1'b0;

      unique case (state_ff)
         itp_pkg::ST_FETCH: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = itp_pkg::ST_WORK;
            end
         end
         itp_pkg::ST_WORK: begin
            unique case (cmd_ff.kind)
               itp_pkg::KIND_ALNUM: begin
                  if (out_free) begin
                     emit                  = 1'b1;
                     emit_data.out_char    = cmd_ff.symbol;
                     emit_data.last_in_run = !cmd_ff.end_of_expr;
                     state_in              = after_state;
                  end
               end
               itp_pkg::KIND_LPAREN: begin
                  do_push  = 1'b1;
                  state_in = after_state;
               end
               itp_pkg::KIND_RPAREN: begin
                  if (has_top && top_ff != itp_pkg::CH_LPAREN) begin
                     if (out_free) begin
                        do_pop = 1'b1;
                        emit   = 1'b1;
                        // Last when the next top is an open paren or nothing is left.
                        emit_data.last_in_run = !cmd_ff.end_of_expr &&
                           (!two_up || below_rd == itp_pkg::CH_LPAREN);
                     end
                  end else begin
                     do_pop   = has_top;
                     state_in = after_state;
                  end
               end
               itp_pkg::KIND_OPER: begin
                  if (has_top && itp_pkg::prec_of(top_ff) >= cmd_ff.prec) begin
                     if (out_free) begin
                        do_pop = 1'b1;
                        emit   = 1'b1;
                        emit_data.last_in_run = !cmd_ff.end_of_expr &&
                           !(two_up && itp_pkg::prec_of(below_rd) >= cmd_ff.prec);
                     end
                  end else begin
                     do_push  = 1'b1;
                     state_in = after_state;
                  end
               end
               itp_pkg::KIND_OTHER: begin
                  state_in = after_state;
               end
               default: begin
                  state_in = after_state;
               end
            endcase
         end
         itp_pkg::ST_FLUSH: begin
            if (out_free) begin
               emit = 1'b1;
               if (has_top) begin
                  do_pop = 1'b1;
               end else begin
                  emit_data.out_char      = itp_pkg::CH_NUL;
                  emit_data.is_terminator = 1'b1;
                  emit_data.last_in_run   = 1'b1;
                  state_in                = itp_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = itp_pkg::ST_FETCH;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      next_in  = next_ff;
      if (do_push && !is_full) begin
         count_in = count_ff + itp_pkg::COUNT_W'(1);
         top_in   = push_char;
         next_in  = top_ff;
      end else if (do_pop) begin
         count_in = count_m1;
         top_in   = next_ff;
         next_in  = third_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itp_pkg::ST_FETCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      top_ff      <= top_in;
      next_ff     <= next_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A push moves the old second entry down into the array.
   always_ff @(posedge clock) begin
      if (do_push && !is_full && two_up) begin
         stack_mem[count_m2[itp_pkg::BELOW_AW-1:0]] <= next_ff;
      end
   end

   // The third entry is kept in a register: a push takes the old second entry,
   // and a pop reads the entry below the third one out of the array.
   always_ff @(posedge clock) begin
      if (do_push && !is_full) begin
         third_ff <= next_ff;
      end else if (do_pop) begin
         third_ff <= stack_mem[count_m4[itp_pkg::BELOW_AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// An accepted item is written into the queue and then into the back sequencer's command
// register; its results go out through the output register. The sequencer pops and emits
// stacked operators one at a time while the output is free; an item with the end flag then
// flushes the stack, then emits a terminator. The two-entry queue takes input meanwhile.
// Reset empties the operator stack, the queue and the output register.

module infix_to_postfix_converter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  itp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itp_pkg::rsp_type  rsp_data
);

   logic              q_full, q_push, q_pop, q_valid;
   itp_pkg::cmd_type  push_cmd, q_cmd;

   itp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   itp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   itp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
